/* rtl/core/tcc_pkg.sv */
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam logic [7:0] CHR_BS    = 8'h08;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_DEL   = 8'h7F;

  localparam int unsigned MaxDigits = 8;

  typedef enum logic [0:0] {
    REG_TEXT_COLOUR = 1'b0,
    REG_BACK_COLOUR = 1'b1
  } cfg_reg_e;

  // one character handed from the digit shifter to the cursor unit
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_step_t;

  // cursor unit result for one character
  typedef struct packed {
    logic       wr;
    logic [7:0] ch;
    logic [6:0] col;
    logic [4:0] row;
    logic       scroll;
    logic [6:0] cur_col;
    logic [4:0] cur_row;
  } cell_res_t;

  function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
    logic [7:0] g;
    if (nib < 4'd10) begin
      g = 8'h30 + {4'h0, nib};
    end else begin
      g = 8'h37 + {4'h0, nib};
    end
    return g;
  endfunction

endpackage

/* rtl/core/tcc_hex_ser.sv */
// ----------------------------------------------------------------------------
// tcc_hex_ser
// Nibble-serial character source: holds one input word and emits one
// character per step, hex digits shifted out most significant first.
// ----------------------------------------------------------------------------
module tcc_hex_ser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               func_i,
  input  logic [7:0]         char_code_i,
  input  logic [31:0]        hex_value_i,
  input  logic [3:0]         hex_digits_i,
  input  logic               step_i,
  output logic               busy_o,
  output tcc_pkg::char_step_t char_o
);
  import tcc_pkg::*;

  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] hex_q, hex_d;
  logic [7:0]  char_q, char_d;
  logic        is_hex_q, is_hex_d;
  logic [3:0]  dig_sat;
  logic [2:0]  pad;

  assign dig_sat = (hex_digits_i > 4'(MaxDigits)) ? 4'(MaxDigits) : hex_digits_i;
  assign pad     = 3'(4'(MaxDigits) - dig_sat);

  always_comb begin
    cnt_d    = cnt_q;
    hex_d    = hex_q;
    char_d   = char_q;
    is_hex_d = is_hex_q;
    if (load_i) begin
      is_hex_d = func_i;
      char_d   = char_code_i;
      hex_d    = hex_value_i << {pad, 2'b00};
      cnt_d    = func_i ? dig_sat : 4'd1;
    end else if (step_i) begin
      hex_d = {hex_q[27:0], 4'h0};
      cnt_d = cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hex_q    <= hex_d;
    char_q   <= char_d;
    is_hex_q <= is_hex_d;
  end

  assign busy_o      = (cnt_q != 4'd0);
  assign char_o.ch   = is_hex_q ? hex_glyph(hex_q[31:28]) : char_q;
  assign char_o.last = (cnt_q == 4'd1);

endmodule

/* rtl/core/tcc_cursor.sv */
// ----------------------------------------------------------------------------
// tcc_cursor
// Cursor position registers and the per-character update: backspace, tab,
// CR, LF, printable cells, line wrap and scroll.
// ----------------------------------------------------------------------------
module tcc_cursor #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         ch_i,
  output tcc_pkg::cell_res_t res_o
);
  import tcc_pkg::*;

  logic [6:0] col_q;
  logic [4:0] row_q;
  logic [7:0] col_n;
  logic [5:0] row_n;
  cell_res_t  res;

  always_comb begin
    res   = '0;
    col_n = {1'b0, col_q};
    row_n = {1'b0, row_q};
    priority if (ch_i == CHR_BS) begin
      if (col_q != 7'd0) begin
        col_n  = col_n - 8'd1;
        res.wr = 1'b1;
      end else if (row_q != 5'd0) begin
        col_n  = 8'(COLUMNS - 1);
        row_n  = row_n - 6'd1;
        res.wr = 1'b1;
      end
      if (res.wr) begin
        res.ch  = CHR_SPACE;
        res.col = col_n[6:0];
        res.row = row_n[4:0];
      end
    end else if (ch_i == CHR_TAB) begin
      col_n = (col_n + 8'd7) & 8'hF8;
    end else if (ch_i == CHR_CR) begin
      col_n = '0;
    end else if (ch_i == CHR_LF) begin
      row_n = row_n + 6'd1;
    end else if (ch_i >= CHR_SPACE && ch_i <= CHR_DEL) begin
      res.wr  = 1'b1;
      res.ch  = ch_i;
      res.col = col_q;
      res.row = row_q;
      col_n   = col_n + 8'd1;
    end else begin
      col_n = {1'b0, col_q};
    end
    if (col_n >= 8'(COLUMNS)) begin
      col_n = '0;
      row_n = row_n + 6'd1;
    end
    if (row_n >= 6'(ROWS)) begin
      res.scroll = 1'b1;
      row_n      = 6'(ROWS - 1);
    end
    res.cur_col = col_n[6:0];
    res.cur_row = row_n[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (step_i) begin
      col_q <= res.cur_col;
      row_q <= res.cur_row;
    end
  end

  assign res_o = res;

endmodule

/* rtl/core/text_console_cursor.sv */
// ----------------------------------------------------------------------------
// text_console_cursor
// Cursor engine of a text console. Each input word is one character or a
// hex value of 0..8 digits (counts above 8 give 8); every character yields
// one output word with the cell write, scroll flag and new cursor position.
//
//   channel | handshake                       | payload
//   --------+---------------------------------+-------------------------------
//   in      | in_valid_i / in_stall_o         | func, char_code, hex_value,
//           |                                 | hex_digits
//   out     | out_valid_o / out_stall_i       | cell_*, scroll_lines,
//           |                                 | cursor_*, last_of_item
//   cfg     | cfg_we_i                        | cfg_idx_i, cfg_data_i
//
// An input word is loaded, then the nibble shift register emits one
// character per cycle while the output is not stalled. The next input word
// is taken the cycle after the last character enters the output register.
// A hex word with zero digits is taken with no output.
// Reset puts the cursor at top left, colours 15 on 0.
// A stalled output holds the register and pauses the character sequence.
// ----------------------------------------------------------------------------
module text_console_cursor #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  char_code_i,
  input  logic [31:0] hex_value_i,
  input  logic [3:0]  hex_digits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        cell_write_o,
  output logic [7:0]  cell_char_o,
  output logic [6:0]  cell_col_o,
  output logic [4:0]  cell_row_o,
  output logic [3:0]  cell_fg_o,
  output logic [3:0]  cell_bg_o,
  output logic        scroll_lines_o,
  output logic [6:0]  cursor_col_o,
  output logic [4:0]  cursor_row_o,
  output logic        last_of_item_o
);
  import tcc_pkg::*;

  logic       busy;
  logic       accept;
  logic       out_free;
  logic       step;
  char_step_t cstep;
  cell_res_t  res;

  logic [3:0] fg_q, bg_q;
  logic       out_valid_q, out_valid_d;
  cell_res_t  out_res_q;
  logic [3:0] out_fg_q, out_bg_q;
  logic       out_last_q;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = busy && out_free;

  tcc_hex_ser u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .func_i       (func_i),
    .char_code_i  (char_code_i),
    .hex_value_i  (hex_value_i),
    .hex_digits_i (hex_digits_i),
    .step_i       (step),
    .busy_o       (busy),
    .char_o       (cstep)
  );

  tcc_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .ch_i   (cstep.ch),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= 4'd15;
      bg_q <= 4'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TEXT_COLOUR: fg_q <= cfg_data_i;
        REG_BACK_COLOUR: bg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_valid_d = step || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q  <= res;
      out_fg_q   <= res.wr ? fg_q : 4'd0;
      out_bg_q   <= res.wr ? bg_q : 4'd0;
      out_last_q <= cstep.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cell_write_o   = out_res_q.wr;
  assign cell_char_o    = out_res_q.ch;
  assign cell_col_o     = out_res_q.col;
  assign cell_row_o     = out_res_q.row;
  assign cell_fg_o      = out_fg_q;
  assign cell_bg_o      = out_bg_q;
  assign scroll_lines_o = out_res_q.scroll;
  assign cursor_col_o   = out_res_q.cur_col;
  assign cursor_row_o   = out_res_q.cur_row;
  assign last_of_item_o = out_last_q;

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, cursor_col_o} < 8'(COLUMNS)) &&
                    ({1'b0, cursor_row_o} < 6'(ROWS)))
    else $error("cursor out of screen");

  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scroll_lines_o |-> cursor_row_o == 5'(ROWS - 1))
    else $error("scroll without cursor on last row");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cell_write_o |->
      (cell_char_o == 8'd0) && (cell_fg_o == 4'd0) && (cell_bg_o == 4'd0))
    else $error("cell fields set without a write");

  a_zero_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && func_i && hex_digits_i == 4'd0 |=> !in_stall_o)
    else $error("empty hex word left the engine busy");

endmodule

/* tb/text_console_cursor_test.sv */
// ----------------------------------------------------------------------------
// text_console_cursor_test
// Self-checking bench for the text console cursor engine. A directed table
// covers backspace wraps, tab rounding, wrap and scroll at the screen edges,
// ignored bytes and hex digit counts of 0, 1, 8, 9 and 15. Random words follow under
// several colour settings. Every output word is compared against a cursor
// predictor, with random gaps and stalls on both sides and one long output
// hold-off that backs up the input.
// ----------------------------------------------------------------------------
module text_console_cursor_test;
  import tcc_pkg::*;

  localparam int SCREEN_COLS  = 80;
  localparam int SCREEN_ROWS  = 25;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int QUIET_CYCLES = 24;
  localparam int HOLD_CYCLES  = 400;
  localparam int NUM_DIR      = 25;

  localparam bit FN_CHAR = 1'b0;
  localparam bit FN_HEX  = 1'b1;

  typedef struct packed {
    bit        func;
    bit [7:0]  code;
    bit [31:0] value;
    bit [3:0]  digits;
    bit [7:0]  reps;
    bit        known;
    bit [6:0]  col;
    bit [4:0]  row;
    bit        scroll;
  } stim_row_t;

  typedef struct packed {
    logic       cell_write;
    logic [7:0] cell_char;
    logic [6:0] cell_col;
    logic [4:0] cell_row;
    logic [3:0] cell_fg;
    logic [3:0] cell_bg;
    logic       scroll_lines;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic       last_of_item;
  } cursor_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [3:0]  cfg_data_i = 4'h0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = 1'b0;
  logic [7:0]  char_code_i = 8'h00;
  logic [31:0] hex_value_i = 32'h0;
  logic [3:0]  hex_digits_i = 4'h0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        cell_write_o;
  logic [7:0]  cell_char_o;
  logic [6:0]  cell_col_o;
  logic [4:0]  cell_row_o;
  logic [3:0]  cell_fg_o;
  logic [3:0]  cell_bg_o;
  logic        scroll_lines_o;
  logic [6:0]  cursor_col_o;
  logic [4:0]  cursor_row_o;
  logic        last_of_item_o;

  // expected cursor of the last output word, travels with the input word
  logic        tag_known = 1'b0;
  logic [6:0]  tag_col = 7'd0;
  logic [4:0]  tag_row = 5'd0;
  logic        tag_scroll = 1'b0;

  cursor_word_t want_q[$];
  int   cur_x = 0;
  int   cur_y = 0;
  logic [3:0] fg_colour = 4'd15;
  logic [3:0] bg_colour = 4'd0;
  int   err_count = 0;
  int   out_words = 0;
  int   cycle_count = 0;
  bit   tx_burst = 1'b0;
  bit   rx_burst = 1'b0;
  bit   hold_req = 1'b0;
  string hex_chars = "0123456789ABCDEF";

  stim_row_t dir_tab [NUM_DIR] = '{
    '{FN_CHAR, 8'h41,     32'h0,        4'd0,  8'd1,  1'b1, 7'd1,  5'd0,  1'b0},
    '{FN_CHAR, CHR_BS,    32'h0,        4'd0,  8'd1,  1'b1, 7'd0,  5'd0,  1'b0},
    '{FN_CHAR, CHR_BS,    32'h0,        4'd0,  8'd1,  1'b1, 7'd0,  5'd0,  1'b0},
    '{FN_CHAR, CHR_TAB,   32'h0,        4'd0,  8'd1,  1'b1, 7'd0,  5'd0,  1'b0},
    '{FN_CHAR, CHR_SPACE, 32'h0,        4'd0,  8'd1,  1'b0, 7'd0,  5'd0,  1'b0},
    '{FN_CHAR, CHR_TAB,   32'h0,        4'd0,  8'd1,  1'b1, 7'd8,  5'd0,  1'b0},
    '{FN_CHAR, CHR_CR,    32'h0,        4'd0,  8'd1,  1'b1, 7'd0,  5'd0,  1'b0},
    '{FN_CHAR, CHR_LF,    32'h0,        4'd0,  8'd1,  1'b1, 7'd0,  5'd1,  1'b0},
    '{FN_CHAR, CHR_BS,    32'h0,        4'd0,  8'd1,  1'b1, 7'd79, 5'd0,  1'b0},
    '{FN_CHAR, CHR_DEL,   32'h0,        4'd0,  8'd1,  1'b1, 7'd0,  5'd1,  1'b0},
    '{FN_CHAR, 8'h00,     32'h0,        4'd0,  8'd1,  1'b1, 7'd0,  5'd1,  1'b0},
    '{FN_CHAR, 8'hFF,     32'h0,        4'd0,  8'd1,  1'b1, 7'd0,  5'd1,  1'b0},
    '{FN_CHAR, 8'h1F,     32'h0,        4'd0,  8'd1,  1'b0, 7'd0,  5'd0,  1'b0},
    '{FN_CHAR, 8'h80,     32'h0,        4'd0,  8'd1,  1'b0, 7'd0,  5'd0,  1'b0},
    '{FN_HEX,  8'h00,     32'hDEADBEEF, 4'd8,  8'd1,  1'b1, 7'd8,  5'd1,  1'b0},
    '{FN_HEX,  8'hFF,     32'h0,        4'd0,  8'd1,  1'b0, 7'd0,  5'd0,  1'b0},
    '{FN_HEX,  8'h00,     32'hFFFFFFFF, 4'd15, 8'd1,  1'b1, 7'd16, 5'd1,  1'b0},
    '{FN_HEX,  8'h00,     32'h5,        4'd1,  8'd1,  1'b0, 7'd0,  5'd0,  1'b0},
    '{FN_HEX,  8'h00,     32'h12345678, 4'd9,  8'd1,  1'b0, 7'd0,  5'd0,  1'b0},
    '{FN_CHAR, CHR_TAB,   32'h0,        4'd0,  8'd1,  1'b1, 7'd32, 5'd1,  1'b0},
    '{FN_CHAR, CHR_LF,    32'h0,        4'd0,  8'd24, 1'b1, 7'd32, 5'd24, 1'b1},
    '{FN_CHAR, CHR_CR,    32'h0,        4'd0,  8'd1,  1'b1, 7'd0,  5'd24, 1'b0},
    '{FN_CHAR, CHR_BS,    32'h0,        4'd0,  8'd1,  1'b1, 7'd79, 5'd23, 1'b0},
    '{FN_CHAR, CHR_LF,    32'h0,        4'd0,  8'd1,  1'b1, 7'd79, 5'd24, 1'b0},
    '{FN_CHAR, CHR_TAB,   32'h0,        4'd0,  8'd1,  1'b1, 7'd0,  5'd24, 1'b1}
  };

  text_console_cursor #(
    .COLUMNS(SCREEN_COLS),
    .ROWS   (SCREEN_ROWS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .char_code_i   (char_code_i),
    .hex_value_i   (hex_value_i),
    .hex_digits_i  (hex_digits_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cell_write_o  (cell_write_o),
    .cell_char_o   (cell_char_o),
    .cell_col_o    (cell_col_o),
    .cell_row_o    (cell_row_o),
    .cell_fg_o     (cell_fg_o),
    .cell_bg_o     (cell_bg_o),
    .scroll_lines_o(scroll_lines_o),
    .cursor_col_o  (cursor_col_o),
    .cursor_row_o  (cursor_row_o),
    .last_of_item_o(last_of_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("text_console_cursor: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("word %0d: %s got %0h want %0h", out_words, what, got, want);
    err_count++;
  endtask

  task automatic advance_cursor(input logic [7:0] ch, input bit last);
    cursor_word_t w;
    w = '0;
    if (ch == CHR_BS) begin
      if (cur_x > 0) begin
        cur_x--;
        w.cell_write = 1'b1;
      end else if (cur_y > 0) begin
        cur_x = SCREEN_COLS - 1;
        cur_y--;
        w.cell_write = 1'b1;
      end
      if (w.cell_write) begin
        w.cell_char = CHR_SPACE;
        w.cell_col  = 7'(cur_x);
        w.cell_row  = 5'(cur_y);
      end
    end else if (ch == CHR_TAB) begin
      cur_x = (cur_x + 7) & ~7;
    end else if (ch == CHR_CR) begin
      cur_x = 0;
    end else if (ch == CHR_LF) begin
      cur_y++;
    end else if (ch >= CHR_SPACE && ch <= CHR_DEL) begin
      w.cell_write = 1'b1;
      w.cell_char  = ch;
      w.cell_col   = 7'(cur_x);
      w.cell_row   = 5'(cur_y);
      cur_x++;
    end
    if (cur_x >= SCREEN_COLS) begin
      cur_x = 0;
      cur_y++;
    end
    if (cur_y >= SCREEN_ROWS) begin
      w.scroll_lines = 1'b1;
      cur_y = SCREEN_ROWS - 1;
    end
    if (w.cell_write) begin
      w.cell_fg = fg_colour;
      w.cell_bg = bg_colour;
    end
    w.cursor_col   = 7'(cur_x);
    w.cursor_row   = 5'(cur_y);
    w.last_of_item = last;
    want_q.push_back(w);
  endtask

  task automatic predict_word(input logic func, input logic [7:0] code,
                              input logic [31:0] value, input logic [3:0] digits,
                              output int produced);
    int n;
    logic [31:0] nib;
    if (func == FN_CHAR) begin
      advance_cursor(code, 1'b1);
      produced = 1;
    end else begin
      n = (digits > MaxDigits) ? MaxDigits : digits;
      for (int i = 0; i < n; i++) begin
        nib = value >> (4 * (n - 1 - i));
        advance_cursor(hex_chars[nib[3:0]], i == n - 1);
      end
      produced = n;
    end
  endtask

  always @(posedge clk_i) begin
    cursor_word_t got;
    cursor_word_t want;
    int produced;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_reg_e'(cfg_idx_i) == REG_TEXT_COLOUR) fg_colour = cfg_data_i;
        else bg_colour = cfg_data_i;
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{cell_write_o, cell_char_o, cell_col_o, cell_row_o, cell_fg_o, cell_bg_o,
                scroll_lines_o, cursor_col_o, cursor_row_o, last_of_item_o};
        if (want_q.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = want_q.pop_front();
          if (got.cell_write != want.cell_write)
            report_mismatch("cell_write", got.cell_write, want.cell_write);
          if (got.cell_char != want.cell_char)
            report_mismatch("cell_char", got.cell_char, want.cell_char);
          if (got.cell_col != want.cell_col)
            report_mismatch("cell_col", got.cell_col, want.cell_col);
          if (got.cell_row != want.cell_row)
            report_mismatch("cell_row", got.cell_row, want.cell_row);
          if (got.cell_fg != want.cell_fg)
            report_mismatch("cell_fg", got.cell_fg, want.cell_fg);
          if (got.cell_bg != want.cell_bg)
            report_mismatch("cell_bg", got.cell_bg, want.cell_bg);
          if (got.scroll_lines != want.scroll_lines)
            report_mismatch("scroll_lines", got.scroll_lines, want.scroll_lines);
          if (got.cursor_col != want.cursor_col)
            report_mismatch("cursor_col", got.cursor_col, want.cursor_col);
          if (got.cursor_row != want.cursor_row)
            report_mismatch("cursor_row", got.cursor_row, want.cursor_row);
          if (got.last_of_item != want.last_of_item)
            report_mismatch("last_of_item", got.last_of_item, want.last_of_item);
        end
        out_words++;
      end
      if (in_valid_i && !in_stall_o) begin
        predict_word(func_i, char_code_i, hex_value_i, hex_digits_i, produced);
        if (tag_known && produced > 0) begin
          want = want_q.pop_back();
          want.cursor_col   = tag_col;
          want.cursor_row   = tag_row;
          want.scroll_lines = tag_scroll;
          want_q.push_back(want);
        end
      end
    end
  end

  // output side: random stall before each word unless in burst mode, one long hold-off on request
  initial begin
    int n;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        n = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        n = rx_burst ? 0 : $urandom_range(0, 14);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_word(input stim_row_t w);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= w.func;
    char_code_i  <= w.code;
    hex_value_i  <= w.value;
    hex_digits_i <= w.digits;
    tag_known    <= w.known;
    tag_col      <= w.col;
    tag_row      <= w.row;
    tag_scroll   <= w.scroll;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_colours(input logic [3:0] fg, input logic [3:0] bg);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_TEXT_COLOUR;
    cfg_data_i <= fg;
    @(posedge clk_i);
    cfg_idx_i  <= REG_BACK_COLOUR;
    cfg_data_i <= bg;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic stim_row_t random_word();
    stim_row_t w;
    int pick;
    w        = '0;
    w.reps   = 8'd1;
    w.code   = 8'($urandom_range(0, 255));
    w.value  = $urandom;
    w.digits = 4'($urandom_range(1, 8));
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      w.func = FN_HEX;
      if ($urandom_range(0, 9) == 0) w.digits = 4'($urandom_range(0, 15));
    end else begin
      w.func = FN_CHAR;
      pick = $urandom_range(0, 99);
      if (pick < 50) w.code = 8'($urandom_range(CHR_SPACE, CHR_DEL));
      else if (pick < 60) w.code = CHR_BS;
      else if (pick < 67) w.code = CHR_TAB;
      else if (pick < 74) w.code = CHR_CR;
      else if (pick < 86) w.code = CHR_LF;
    end
    return w;
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) send_word(random_word());
  endtask

  initial begin
    stim_row_t w;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      for (int k = 0; k < dir_tab[i].reps; k++) begin
        w = dir_tab[i];
        if (k != dir_tab[i].reps - 1) w.known = 1'b0;
        send_word(w);
      end
    end
    wait_idle();

    write_colours(4'd0, 4'd15);
    tx_burst = 1'b1;
    hold_req = 1'b1;
    run_random(66);
    wait_idle();

    write_colours(4'd15, 4'd15);
    rx_burst = 1'b1;
    run_random(66);
    wait_idle();

    write_colours(4'd0, 4'd0);
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    run_random(65);
    wait_idle();

    write_colours(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    run_random(65);
    wait_idle();

    if (want_q.size() != 0) report_mismatch("words missing", want_q.size(), 0);
    if (err_count == 0) begin
      $display("text_console_cursor: match");
    end else begin
      $display("text_console_cursor: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/tcc_pkg.sv
rtl/core/tcc_hex_ser.sv
rtl/core/tcc_cursor.sv
rtl/core/text_console_cursor.sv
tb/text_console_cursor_test.sv
